// ===== hdl/opct_pkg.sv =====
`default_nettype none

package opct_pkg;

  localparam int unsigned KindW  = 6;
  localparam int unsigned StartW = 16;
  localparam int unsigned MaxRes = 3;

  localparam logic [KindW-1:0] KindArrow    = 6'd0;
  localparam logic [KindW-1:0] KindDec      = 6'd1;
  localparam logic [KindW-1:0] KindMinusQ   = 6'd2;
  localparam logic [KindW-1:0] KindMinus    = 6'd3;
  localparam logic [KindW-1:0] KindInc      = 6'd4;
  localparam logic [KindW-1:0] KindPlus     = 6'd5;
  localparam logic [KindW-1:0] KindFatArrow = 6'd6;
  localparam logic [KindW-1:0] KindEqEq     = 6'd7;
  localparam logic [KindW-1:0] KindEqQ      = 6'd8;
  localparam logic [KindW-1:0] KindEq       = 6'd9;
  localparam logic [KindW-1:0] KindAndAnd   = 6'd10;
  localparam logic [KindW-1:0] KindAndQ     = 6'd11;
  localparam logic [KindW-1:0] KindAnd      = 6'd12;
  localparam logic [KindW-1:0] KindLe       = 6'd13;
  localparam logic [KindW-1:0] KindLArrow   = 6'd14;
  localparam logic [KindW-1:0] KindShl      = 6'd15;
  localparam logic [KindW-1:0] KindLt       = 6'd16;
  localparam logic [KindW-1:0] KindOrOr     = 6'd17;
  localparam logic [KindW-1:0] KindOr       = 6'd18;
  localparam logic [KindW-1:0] KindGe       = 6'd19;
  localparam logic [KindW-1:0] KindShr      = 6'd20;
  localparam logic [KindW-1:0] KindGt       = 6'd21;
  localparam logic [KindW-1:0] KindPow      = 6'd22;
  localparam logic [KindW-1:0] KindStar     = 6'd23;
  localparam logic [KindW-1:0] KindComma    = 6'd24;
  localparam logic [KindW-1:0] KindSemi     = 6'd25;
  localparam logic [KindW-1:0] KindColon    = 6'd26;
  localparam logic [KindW-1:0] KindCaret    = 6'd27;
  localparam logic [KindW-1:0] KindPercent  = 6'd28;
  localparam logic [KindW-1:0] KindBang     = 6'd29;
  localparam logic [KindW-1:0] KindHash     = 6'd30;
  localparam logic [KindW-1:0] KindQuest    = 6'd31;
  localparam logic [KindW-1:0] KindLParen   = 6'd32;
  localparam logic [KindW-1:0] KindLBrack   = 6'd33;
  localparam logic [KindW-1:0] KindLBrace   = 6'd34;
  localparam logic [KindW-1:0] KindRParen   = 6'd35;
  localparam logic [KindW-1:0] KindRBrack   = 6'd36;
  localparam logic [KindW-1:0] KindRBrace   = 6'd37;
  localparam logic [KindW-1:0] KindDot      = 6'd38;
  localparam logic [KindW-1:0] KindSlash    = 6'd39;
  localparam logic [KindW-1:0] KindInvalid  = 6'd40;
  localparam logic [KindW-1:0] KindEnd      = 6'd41;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChDot   = 8'h2E;

  typedef struct packed {
    logic [1:0]                    count;
    logic [MaxRes-1:0][KindW-1:0]  kind;
    logic [MaxRes-1:0][StartW-1:0] start;
  } opct_res_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [StartW-1:0] start;
    logic              last;
  } opct_beat_t;

  function automatic logic [KindW-1:0] single_kind(input logic [7:0] c);
    logic [KindW-1:0] k;
    case (c)
      8'h2D:   k = KindMinus;
      8'h2B:   k = KindPlus;
      8'h3D:   k = KindEq;
      8'h26:   k = KindAnd;
      8'h3C:   k = KindLt;
      8'h7C:   k = KindOr;
      8'h3E:   k = KindGt;
      8'h2A:   k = KindStar;
      8'h2C:   k = KindComma;
      8'h3B:   k = KindSemi;
      8'h3A:   k = KindColon;
      8'h5E:   k = KindCaret;
      8'h25:   k = KindPercent;
      8'h21:   k = KindBang;
      8'h23:   k = KindHash;
      8'h3F:   k = KindQuest;
      8'h28:   k = KindLParen;
      8'h5B:   k = KindLBrack;
      8'h7B:   k = KindLBrace;
      8'h29:   k = KindRParen;
      8'h5D:   k = KindRBrack;
      8'h7D:   k = KindRBrace;
      8'h2E:   k = KindDot;
      8'h2F:   k = KindSlash;
      default: k = KindInvalid;
    endcase
    return k;
  endfunction

  // Returns KindInvalid when the two bytes do not form an operator.
  function automatic logic [KindW-1:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    logic [KindW-1:0] k;
    k = KindInvalid;
    case (a)
      8'h2D: begin
        if (b == 8'h3E) k = KindArrow;
        else if (b == 8'h2D) k = KindDec;
        else if (b == 8'h3F) k = KindMinusQ;
      end
      8'h2B: begin
        if (b == 8'h2B) k = KindInc;
      end
      8'h3D: begin
        if (b == 8'h3E) k = KindFatArrow;
        else if (b == 8'h3D) k = KindEqEq;
        else if (b == 8'h3F) k = KindEqQ;
      end
      8'h26: begin
        if (b == 8'h26) k = KindAndAnd;
        else if (b == 8'h3F) k = KindAndQ;
      end
      8'h3C: begin
        if (b == 8'h3D) k = KindLe;
        else if (b == 8'h2D) k = KindLArrow;
        else if (b == 8'h3C) k = KindShl;
      end
      8'h7C: begin
        if (b == 8'h7C) k = KindOrOr;
      end
      8'h3E: begin
        if (b == 8'h3D) k = KindGe;
        else if (b == 8'h3E) k = KindShr;
      end
      8'h2A: begin
        if (b == 8'h2A) k = KindPow;
      end
      default: k = KindInvalid;
    endcase
    return k;
  endfunction

  function automatic logic may_pair(input logic [7:0] c);
    return (c == 8'h2D) || (c == 8'h2B) || (c == 8'h3D) || (c == 8'h26) ||
           (c == 8'h3C) || (c == 8'h7C) || (c == 8'h3E) || (c == 8'h2A);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/opct_scan.sv =====
`default_nettype none

module opct_scan #(
  parameter int unsigned MAX_TEXT_BYTES = 65536
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              take_i,
  input  wire logic [7:0]        text_byte_i,
  input  wire logic              final_byte_i,
  output opct_pkg::opct_res_t    res_o
);

  import opct_pkg::*;

  localparam int unsigned OffW = $clog2(MAX_TEXT_BYTES);
  localparam logic [OffW-1:0] LastOff = OffW'(MAX_TEXT_BYTES - 1);

  localparam logic [2:0] ModeIdle  = 3'd0;
  localparam logic [2:0] ModeOp    = 3'd1;
  localparam logic [2:0] ModeDot1  = 3'd2;
  localparam logic [2:0] ModeDot2  = 3'd3;
  localparam logic [2:0] ModeLine  = 3'd4;
  localparam logic [2:0] ModeBlock = 3'd5;

  logic [2:0]      mode_q, mode_d;
  logic [7:0]      held_char_q, held_char_d;
  logic [OffW-1:0] held_start_q, held_start_d;
  logic [OffW-1:0] offset_q, offset_d;
  logic [1:0]      dots_q, dots_d;

  logic [OffW-1:0]   next_off;
  logic [OffW+15:0]  pos_ext, held_ext, next_ext;
  logic [StartW-1:0] pos16, held16, next16;
  logic [7:0]        c;
  logic              c_ws, c_dot;
  logic [KindW-1:0]  c_kind, pk, held_kind;

  assign c         = text_byte_i;
  assign next_off  = (offset_q == LastOff) ? '0 : offset_q + OffW'(1);
  assign pos_ext   = {16'b0, offset_q};
  assign held_ext  = {16'b0, held_start_q};
  assign next_ext  = {16'b0, next_off};
  assign pos16     = pos_ext[15:0];
  assign held16    = held_ext[15:0];
  assign next16    = next_ext[15:0];
  assign c_ws      = (c == ChCr) || (c == ChLf) || (c == ChSpace) || (c == ChTab);
  assign c_dot     = (c == ChDot);
  assign c_kind    = single_kind(c);
  assign pk        = pair_kind(held_char_q, c);
  assign held_kind = single_kind(held_char_q);

  always_comb begin
    logic [1:0] n;
    logic       do_idle;
    n            = 2'd0;
    do_idle      = 1'b0;
    res_o        = '0;
    mode_d       = mode_q;
    held_char_d  = held_char_q;
    held_start_d = held_start_q;
    dots_d       = dots_q;
    offset_d     = next_off;

    case (mode_q)
      ModeOp: begin
        mode_d = ModeIdle;
        if (pk != KindInvalid) begin
          res_o.kind[n]  = pk;
          res_o.start[n] = held16;
          n = n + 2'd1;
        end else begin
          res_o.kind[n]  = held_kind;
          res_o.start[n] = held16;
          n = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      ModeDot1: begin
        if (c_dot) begin
          mode_d = ModeDot2;
        end else begin
          mode_d = ModeIdle;
          res_o.kind[n]  = KindDot;
          res_o.start[n] = held16;
          n = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      ModeDot2: begin
        if (c_dot) begin
          mode_d = ModeBlock;
          dots_d = 2'd0;
        end else begin
          mode_d = (c == ChLf) ? ModeIdle : ModeLine;
        end
      end
      ModeLine: begin
        if (c == ChLf) mode_d = ModeIdle;
      end
      ModeBlock: begin
        if (c_dot) begin
          if (dots_q >= 2'd2) begin
            mode_d = ModeIdle;
            dots_d = 2'd0;
          end else begin
            dots_d = dots_q + 2'd1;
          end
        end else begin
          dots_d = 2'd0;
        end
      end
      default: begin
        mode_d  = ModeIdle;
        do_idle = 1'b1;
      end
    endcase

    if (do_idle && !c_ws) begin
      if (c_dot) begin
        mode_d       = ModeDot1;
        held_start_d = offset_q;
      end else if (may_pair(c)) begin
        mode_d       = ModeOp;
        held_char_d  = c;
        held_start_d = offset_q;
      end else begin
        res_o.kind[n]  = c_kind;
        res_o.start[n] = pos16;
        n = n + 2'd1;
      end
    end

    if (final_byte_i) begin
      if (mode_d == ModeOp) begin
        res_o.kind[n]  = single_kind(held_char_d);
        res_o.start[n] = held_start_d == offset_q ? pos16 : held16;
        n = n + 2'd1;
      end else if (mode_d == ModeDot1) begin
        res_o.kind[n]  = KindDot;
        res_o.start[n] = held_start_d == offset_q ? pos16 : held16;
        n = n + 2'd1;
      end
      res_o.kind[n]  = KindEnd;
      res_o.start[n] = next16;
      n = n + 2'd1;
      mode_d       = ModeIdle;
      held_char_d  = '0;
      held_start_d = '0;
      offset_d     = '0;
      dots_d       = '0;
    end

    res_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeIdle;
      held_char_q  <= '0;
      held_start_q <= '0;
      offset_q     <= '0;
      dots_q       <= '0;
    end else if (take_i) begin
      mode_q       <= mode_d;
      held_char_q  <= held_char_d;
      held_start_q <= held_start_d;
      offset_q     <= offset_d;
      dots_q       <= dots_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/operator_and_comment_tokenizer_top.sv =====
// Channel  Direction  tdata (low bit up)     tlast         tuser (low bit up)
// s_axis   in         text_byte[7:0]         final_byte    -
// m_axis   out        token_start[15:0]      last_of_run   token_kind[5:0]
//
// Each input beat is scanned in the cycle it is accepted; its zero to three
// tokens go into a four-entry result queue, drained one beat per cycle while
// m_axis_tready is high. Input beats are taken every cycle while the queue
// holds at most one token; multi-token bytes and back-pressure cause stalls.
// Reset returns the scanner to the start of a text and empties the queue.
`default_nettype none

module operator_and_comment_tokenizer_top #(
  parameter int unsigned MAX_TEXT_BYTES = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // text_byte
  input  wire logic        s_axis_tlast,   // final_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // token_start
  output logic [5:0]       m_axis_tuser,   // token_kind
  output logic             m_axis_tlast    // last_of_run
);

  import opct_pkg::*;

  opct_res_t  res;
  opct_beat_t queue_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] count_q;
  logic       take, pop;
  logic [2:0] push_n;

  assign s_axis_tready = (count_q <= 3'd1);
  assign take          = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (count_q != 3'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign push_n        = take ? {1'b0, res.count} : 3'd0;
  assign m_axis_tdata  = queue_q[rd_q].start;
  assign m_axis_tuser  = queue_q[rd_q].kind;
  assign m_axis_tlast  = queue_q[rd_q].last;

  opct_scan #(
    .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .text_byte_i (s_axis_tdata),
    .final_byte_i(s_axis_tlast),
    .res_o       (res)
  );

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (take && (2'(i) < res.count)) begin
        queue_q[wr_q + 2'(i)].kind  <= res.kind[i];
        queue_q[wr_q + 2'(i)].start <= res.start[i];
        queue_q[wr_q + 2'(i)].last  <= (2'(i) == res.count - 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= '0;
      wr_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + push_n[1:0];
      rd_q    <= rd_q + {1'b0, pop};
      count_q <= count_q + push_n - {2'b00, pop};
    end
  end

endmodule

`default_nettype wire
